/* hdl/gdc_pkg.sv */
// Shared widths, codes, calendar tables and the microcode ROM of the date counter.
package gdc_pkg;

  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 22;
  localparam int DAYN_W   = COUNT_W + 1;  // day number of any 14-bit year
  localparam int STATUS_W = 3;
  localparam int STEP_W   = 5;
  localparam int QUOT_W   = 8;   // year / 100 for a 14-bit year
  localparam int MUL_B_W  = 13;
  localparam int PROD_W   = YEAR_W + MUL_B_W;

  localparam int YEAR_MAX_DEFAULT = 9999;

  localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(1900);
  localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_DEC_END = DAY_W'(31);

  // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
  localparam logic [MUL_B_W-1:0] DIV100_MUL    = MUL_B_W'(5243);
  localparam int                 DIV100_SHIFT  = 19;
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = MUL_B_W'(365);

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_NEXT = 2'd1,
    KIND_PREV = 2'd2,
    KIND_DIFF = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_YEAR  = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    UOP_LOAD_IN,
    UOP_LOAD_CUR,
    UOP_DIVY,
    UOP_DIVP,
    UOP_LEAP,
    UOP_MUL,
    UOP_DAYN,
    UOP_DIFF,
    UOP_CHECK,
    UOP_SET_APPLY,
    UOP_INC,
    UOP_DEC,
    UOP_FINISH
  } uop_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_JUMP_ERR,
    SEQ_END
  } seq_t;

  typedef struct packed {
    uop_t              op;
    seq_t              seq;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [STEP_W-1:0] ENTRY_SET  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ENTRY_NEXT = STEP_W'(5);
  localparam logic [STEP_W-1:0] ENTRY_PREV = STEP_W'(6);
  localparam logic [STEP_W-1:0] ENTRY_DIFF = STEP_W'(7);
  localparam logic [STEP_W-1:0] ENTRY_TAIL = STEP_W'(21);

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w.target = ENTRY_TAIL;
    w.seq    = SEQ_NEXT;
    case (step)
      // set date
      5'd0:  w.op = UOP_LOAD_IN;
      5'd1:  w.op = UOP_DIVY;
      5'd2:  w.op = UOP_LEAP;
      5'd3:  w.op = UOP_CHECK;
      5'd4:  begin w.op = UOP_SET_APPLY; w.seq = SEQ_JUMP; end
      // single-day steps
      5'd5:  begin w.op = UOP_INC; w.seq = SEQ_JUMP; end
      5'd6:  begin w.op = UOP_DEC; w.seq = SEQ_JUMP; end
      // difference: other date first
      5'd7:  w.op = UOP_LOAD_IN;
      5'd8:  w.op = UOP_DIVY;
      5'd9:  w.op = UOP_LEAP;
      5'd10: w.op = UOP_CHECK;
      5'd11: begin w.op = UOP_DIVP; w.seq = SEQ_JUMP_ERR; end
      5'd12: w.op = UOP_MUL;
      5'd13: w.op = UOP_DAYN;
      // then the held date
      5'd14: w.op = UOP_LOAD_CUR;
      5'd15: w.op = UOP_DIVY;
      5'd16: w.op = UOP_LEAP;
      5'd17: w.op = UOP_DIVP;
      5'd18: w.op = UOP_MUL;
      5'd19: w.op = UOP_DAYN;
      5'd20: w.op = UOP_DIFF;
      // common tail: refresh the leap flag of the held year, post the result
      5'd21: w.op = UOP_LOAD_CUR;
      5'd22: w.op = UOP_DIVY;
      5'd23: w.op = UOP_LEAP;
      5'd24: begin w.op = UOP_FINISH; w.seq = SEQ_END; end
      default: begin w.op = UOP_FINISH; w.seq = SEQ_END; end
    endcase
    return w;
  endfunction

  function automatic logic [DAY_W-1:0] month_end(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (month)
      4'd2:    r = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
      default: r = DAY_W'(31);
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
    logic [8:0] r;
    case (month)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/gdc_ifs.sv */
// Valid/ready channel interfaces for the date counter's command and result beats.
interface gdc_cmd_if import gdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [MONTH_W-1:0] month_in;
  logic [DAY_W-1:0]   day_in;
  logic [YEAR_W-1:0]  year_in;

  modport source (output valid, kind, month_in, day_in, year_in, input ready);
  modport sink   (input valid, kind, month_in, day_in, year_in, output ready);
endinterface

interface gdc_res_if import gdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [YEAR_W-1:0]   year_out;
  logic                leap_out;
  logic [DAY_W-1:0]    month_length;
  logic [COUNT_W-1:0]  day_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, month_out, day_out, year_out, leap_out, month_length,
                  day_count, status, input ready);
  modport sink   (input valid, month_out, day_out, year_out, leap_out, month_length,
                  day_count, status, output ready);
endinterface

/* hdl/gregorian_date_counter.sv */
// Gregorian date counter: microcoded sequencer over a small calendar datapath.
//
// Usage. One command beat on cmd (kind, month_in, day_in, year_in) yields one
// result beat on res: the held date after the operation, its leap flag, the
// last day of its month, a day count (difference only) and a status code.
// kind 0 sets the date with validation, 1 and 2 step one day forward or back,
// 3 counts the days from the given earlier date up to the held date.
//
// Each command runs a microprogram, one control word per cycle (the final
// step waits while a result is pending, see below), over one shared
// multiplier. Set date and difference run longer programs than next /
// previous day; difference takes a shorter path if the other date is invalid.
// cmd.ready is high while no program runs, so a new command is taken the
// cycle after the previous program ends, and not while a program runs.
// The result sits in an output register.
// If res is stalled, the final step of the next program waits until the
// pending result is taken; nothing is dropped or overwritten.
// Reset (synchronous, active high) holds 1/1/1900, clears the sequencer and
// drops any pending result.
module gregorian_date_counter
  import gdc_pkg::*;
#(
  parameter int YEAR_MAX = YEAR_MAX_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  gdc_cmd_if.sink   cmd,
  gdc_res_if.source res
);

  localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(YEAR_MAX);
  localparam logic [YEAR_W-1:0] YEAR_ONE   = YEAR_W'(1);

  // sequencer
  logic              busy;
  logic [STEP_W-1:0] step;
  uword_t            uw;
  logic              advance;

  // held date and its leap flag
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [YEAR_W-1:0]  cur_year;
  logic               cur_leap;

  // latched command operands
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [YEAR_W-1:0]  in_year;

  // work registers
  logic [MONTH_W-1:0] wm;
  logic [DAY_W-1:0]   wd;
  logic [YEAR_W-1:0]  wy;
  logic [QUOT_W-1:0]  q;      // wy / 100
  logic [QUOT_W-1:0]  qp;     // (wy - 1) / 100
  logic               lp;     // leap flag of wy
  logic [DAYN_W-1:0]  t;      // (wy - 1) * 365
  logic [DAYN_W-1:0]  num;
  logic [DAYN_W-1:0]  num_prev;
  logic [COUNT_W-1:0] count;
  status_t            status;

  // output register
  logic                out_valid;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [YEAR_W-1:0]   out_year;
  logic                out_leap;
  logic [DAY_W-1:0]    out_mlen;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;

  // combinational datapath
  logic [YEAR_W-1:0]  p;
  logic [YEAR_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W:0]    q100;
  logic               leap_calc;
  logic [DAYN_W-1:0]  dayn_sum;
  logic [DAY_W-1:0]   cur_end;
  logic [DAY_W-1:0]   prev_end;
  logic [DAY_W-1:0]   in_end;
  logic [STEP_W-1:0]  entry;
  logic [MONTH_W-1:0] cur_month_dn;

  assign uw = ucode(step);

  // the final step stalls while an earlier result is still waiting
  assign advance = !(uw.op == UOP_FINISH && out_valid && !res.ready);

  assign p     = wy - YEAR_ONE;
  assign mul_a = (uw.op == UOP_DIVY) ? wy : p;
  assign mul_b = (uw.op == UOP_MUL) ? DAYS_PER_YEAR : DIV100_MUL;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // leap: divisible by 4 and not by 100, or divisible by 400
  assign q100      = (YEAR_W + 1)'(q) * (YEAR_W + 1)'(100);
  assign leap_calc = (q100 == {1'b0, wy}) ? (q[1:0] == 2'b00) : (wy[1:0] == 2'b00);

  // day number of (wm, wd, wy), 1/1/1 counting as day 1
  assign dayn_sum = t
                  + DAYN_W'(p >> 2)
                  - DAYN_W'(qp)
                  + DAYN_W'(qp >> 2)
                  + DAYN_W'(days_before(wm))
                  + DAYN_W'((wm > MONTH_FEB) && lp)
                  + DAYN_W'(wd);

  assign cur_month_dn = cur_month - MONTH_W'(1);
  assign cur_end      = month_end(cur_month, cur_leap);
  assign prev_end     = month_end(cur_month_dn, cur_leap);
  assign in_end       = month_end(in_month, lp);

  always_comb begin
    case (kind_t'(cmd.kind))
      KIND_SET:  entry = ENTRY_SET;
      KIND_NEXT: entry = ENTRY_NEXT;
      KIND_PREV: entry = ENTRY_PREV;
      KIND_DIFF: entry = ENTRY_DIFF;
      default:   entry = ENTRY_SET;
    endcase
  end

  assign cmd.ready = !busy;

  // sequencer: step counter with conditional jumps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ENTRY_SET;
    end else if (!busy) begin
      if (cmd.valid) begin
        busy <= 1'b1;
        step <= entry;
      end
    end else if (advance) begin
      case (uw.seq)
        SEQ_NEXT:     step <= step + STEP_W'(1);
        SEQ_JUMP:     step <= uw.target;
        SEQ_JUMP_ERR: step <= (status != ST_OK) ? uw.target : step + STEP_W'(1);
        SEQ_END:      busy <= 1'b0;
        default:      busy <= 1'b0;
      endcase
    end
  end

  // held date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_month <= MONTH_JAN;
      cur_day   <= DAY_FIRST;
      cur_year  <= RESET_YEAR;
      cur_leap  <= 1'b0;
    end else if (busy && advance) begin
      case (uw.op)
        UOP_SET_APPLY: begin
          if (status == ST_OK) begin
            cur_month <= in_month;
            cur_day   <= in_day;
            cur_year  <= in_year;
          end else begin
            cur_month <= MONTH_JAN;
            cur_day   <= DAY_FIRST;
            cur_year  <= RESET_YEAR;
          end
        end
        UOP_INC: begin
          if (cur_day == cur_end) begin
            if (cur_month == MONTH_DEC) begin
              if (cur_year < YEAR_LIMIT) begin
                cur_day   <= DAY_FIRST;
                cur_month <= MONTH_JAN;
                cur_year  <= cur_year + YEAR_ONE;
              end
            end else begin
              cur_day   <= DAY_FIRST;
              cur_month <= cur_month + MONTH_W'(1);
            end
          end else begin
            cur_day <= cur_day + DAY_W'(1);
          end
        end
        UOP_DEC: begin
          if (cur_day == DAY_FIRST) begin
            if (cur_month == MONTH_JAN) begin
              if (cur_year > YEAR_ONE) begin
                cur_month <= MONTH_DEC;
                cur_day   <= DAY_DEC_END;
                cur_year  <= cur_year - YEAR_ONE;
              end
            end else begin
              cur_month <= cur_month_dn;
              cur_day   <= prev_end;
            end
          end else begin
            cur_day <= cur_day - DAY_W'(1);
          end
        end
        UOP_FINISH: cur_leap <= lp;
        default: ;
      endcase
    end
  end

  // operand latch, work registers and status
  always_ff @(posedge clk) begin
    if (!busy && cmd.valid) begin
      in_month <= cmd.month_in;
      in_day   <= cmd.day_in;
      in_year  <= cmd.year_in;
      status   <= ST_OK;
      count    <= '0;
    end else if (busy && advance) begin
      case (uw.op)
        UOP_LOAD_IN: begin
          wm <= in_month;
          wd <= in_day;
          wy <= in_year;
        end
        UOP_LOAD_CUR: begin
          wm <= cur_month;
          wd <= cur_day;
          wy <= cur_year;
        end
        UOP_DIVY: q  <= prod[DIV100_SHIFT +: QUOT_W];
        UOP_DIVP: qp <= prod[DIV100_SHIFT +: QUOT_W];
        UOP_LEAP: lp <= leap_calc;
        UOP_MUL:  t  <= prod[DAYN_W-1:0];
        UOP_DAYN: begin
          num      <= dayn_sum;
          num_prev <= num;
        end
        UOP_DIFF: count <= (num > num_prev) ? COUNT_W'(num - num_prev) : '0;
        UOP_CHECK: begin
          if (in_month < MONTH_JAN || in_month > MONTH_DEC) begin
            status <= ST_BAD_MONTH;
          end else if (in_year < YEAR_ONE || in_year > YEAR_LIMIT) begin
            status <= ST_BAD_YEAR;
          end else if (in_day < DAY_FIRST || in_day > in_end) begin
            status <= ST_BAD_DAY;
          end
        end
        UOP_INC: begin
          if (cur_day == cur_end && cur_month == MONTH_DEC && cur_year >= YEAR_LIMIT) begin
            status <= ST_RANGE;
          end
        end
        UOP_DEC: begin
          if (cur_day == DAY_FIRST && cur_month == MONTH_JAN && cur_year <= YEAR_ONE) begin
            status <= ST_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && uw.op == UOP_FINISH && advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && uw.op == UOP_FINISH && advance) begin
      out_month  <= cur_month;
      out_day    <= cur_day;
      out_year   <= cur_year;
      out_leap   <= lp;
      out_mlen   <= month_end(cur_month, lp);
      out_count  <= count;
      out_status <= status;
    end
  end

  assign res.valid        = out_valid;
  assign res.month_out    = out_month;
  assign res.day_out      = out_day;
  assign res.year_out     = out_year;
  assign res.leap_out     = out_leap;
  assign res.month_length = out_mlen;
  assign res.day_count    = out_count;
  assign res.status       = out_status;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the Gregorian date counter: random and directed calendar commands.
`timescale 1ns / 1ps

module tb_top
  import gdc_pkg::*;
();

  localparam int unsigned YEAR_LIMIT   = YEAR_MAX_DEFAULT;
  localparam int          QUIET_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int          HOLD_CYCLES  = 400;   // long result back-pressure stretch
  localparam int          SETTLE_TICKS = 30;    // margin for the longest program

  // days before the first of each month in a common year, index 1..12
  localparam int unsigned CUM_DAYS [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                            273, 304, 334};

  typedef struct packed {
    kind_t              kind;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
  } cmd_beat_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } date_result_t;

  logic clk;
  logic rst;

  gdc_cmd_if cmd ();
  gdc_res_if res ();

  gregorian_date_counter #(.YEAR_MAX(YEAR_LIMIT)) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // commands waiting to be offered, and the results they will produce
  cmd_beat_t    cmd_q    [$];
  date_result_t result_q [$];

  // held date of the shadow calendar
  int unsigned cal_month = 1;
  int unsigned cal_day   = 1;
  int unsigned cal_year  = 1900;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        hold_arm      = 1'b0;
  int          hold_left     = 0;
  logic        cmd_taken     = 1'b0;
  int          quiet_cycles  = 0;
  int          mismatches    = 0;
  int          queued        = 0;

  // --------------------------------------------------------------------------
  // Calendar arithmetic for the shadow model
  // --------------------------------------------------------------------------
  function automatic logic is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned last_day(int unsigned m, int unsigned y);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // month is judged first, then year, then day against that month
  function automatic status_t date_error(int unsigned m, int unsigned d, int unsigned y);
    if (m < 1 || m > 12) return ST_BAD_MONTH;
    if (y < 1 || y > YEAR_LIMIT) return ST_BAD_YEAR;
    if (d < 1 || d > last_day(m, y)) return ST_BAD_DAY;
    return ST_OK;
  endfunction

  // ordinal day of a valid date, 1/1/1 being day 1
  function automatic int unsigned day_index(int unsigned m, int unsigned d, int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400 + CUM_DAYS[m];
    if (m > 2 && is_leap(y)) n++;
    return n + d;
  endfunction

  // Advance the shadow calendar by one command and form the result it yields.
  task automatic apply_command(input cmd_beat_t c, output date_result_t r);
    status_t     st;
    int unsigned span;
    int unsigned here;
    int unsigned there;
    int unsigned mlen;
    st   = ST_OK;
    span = 0;
    case (c.kind)
      KIND_SET: begin
        st = date_error(c.month, c.day, c.year);
        if (st == ST_OK) begin
          cal_month = c.month;
          cal_day   = c.day;
          cal_year  = c.year;
        end else begin
          // any rejected date falls back to the reset date
          cal_month = 1;
          cal_day   = 1;
          cal_year  = 1900;
        end
      end
      KIND_NEXT: begin
        if (cal_day != last_day(cal_month, cal_year)) begin
          cal_day++;
        end else if (cal_month != 12) begin
          cal_day = 1;
          cal_month++;
        end else if (cal_year >= YEAR_LIMIT) begin
          st = ST_RANGE;                      // hold the last representable day
        end else begin
          cal_day   = 1;
          cal_month = 1;
          cal_year++;
        end
      end
      KIND_PREV: begin
        if (cal_day != 1) begin
          cal_day--;
        end else if (cal_month != 1) begin
          cal_month--;
          cal_day = last_day(cal_month, cal_year);
        end else if (cal_year <= 1) begin
          st = ST_RANGE;                      // hold 1/1/1
        end else begin
          cal_month = 12;
          cal_day   = 31;
          cal_year--;
        end
      end
      default: begin
        // difference: the other date is validated but the held date stays
        st = date_error(c.month, c.day, c.year);
        if (st == ST_OK) begin
          here  = day_index(cal_month, cal_day, cal_year);
          there = day_index(c.month, c.day, c.year);
          span  = (here > there) ? here - there : 0;
        end
      end
    endcase
    mlen     = last_day(cal_month, cal_year);
    r.month  = cal_month[MONTH_W-1:0];
    r.day    = cal_day[DAY_W-1:0];
    r.year   = cal_year[YEAR_W-1:0];
    r.leap   = is_leap(cal_year);
    r.mlen   = mlen[DAY_W-1:0];
    r.count  = span[COUNT_W-1:0];
    r.status = st;
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold every block input at a known value from time zero; the driver
  // processes take over at the first falling edge.
  initial begin
    rst          = 1'b1;
    cmd.valid    = 1'b0;
    cmd.kind     = KIND_SET;
    cmd.month_in = '0;
    cmd.day_in   = '0;
    cmd.year_in  = '0;
    res.ready    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Command driver: updates at the falling edge. An offered beat stays on the
  // bus until the rising edge takes it; a fresh beat is offered only when the
  // idle roll passes.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cmd
    cmd_beat_t nxt;
    logic      busy;
    busy = cmd.valid && !cmd_taken;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!busy) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = cmd_q.pop_front();
        cmd.valid    <= 1'b1;
        cmd.kind     <= nxt.kind;
        cmd.month_in <= nxt.month;
        cmd.day_in   <= nxt.day;
        cmd.year_in  <= nxt.year;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stalls, plus the long hold while armed.
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Long-hold counter, loaded by the stimulus process and run down here.
  always @(posedge clk) begin : hold_timer
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check the result beat
  // first so that a result is never paired with a command taken in the same
  // cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    cmd_beat_t    took;
    date_result_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd.valid && cmd.ready;
      if (res.valid && res.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d/%0d/%0d with nothing outstanding",
                                    res.month_out, res.day_out, res.year_out));
        end else begin
          want = result_q.pop_front();
          check_field("month_out",    res.month_out,    want.month);
          check_field("day_out",      res.day_out,      want.day);
          check_field("year_out",     res.year_out,     want.year);
          check_field("leap_out",     res.leap_out,     want.leap);
          check_field("month_length", res.month_length, want.mlen);
          check_field("day_count",    res.day_count,    want.count);
          check_field("status",       res.status,       want.status);
        end
      end
      if (cmd.valid && cmd.ready) begin
        took.kind  = kind_t'(cmd.kind);
        took.month = cmd.month_in;
        took.day   = cmd.day_in;
        took.year  = cmd.year_in;
        apply_command(took, want);
        result_q.push_back(want);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ERROR no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL gregorian_date_counter");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic cmd_beat_t mk(kind_t k, int unsigned m, int unsigned d, int unsigned y);
    cmd_beat_t c;
    c.kind  = k;
    c.month = m[MONTH_W-1:0];
    c.day   = d[DAY_W-1:0];
    c.year  = y[YEAR_W-1:0];
    return c;
  endfunction

  task automatic queue_cmd(cmd_beat_t c);
    cmd_q.push_back(c);
    queued++;
  endtask

  // Years biased toward the range ends and the century leap rules.
  function automatic int unsigned pick_year();
    case ($urandom_range(9))
      0:       return 1;
      1:       return YEAR_LIMIT;
      2:       return $urandom_range(1) ? 2 : YEAR_LIMIT - 1;
      3:       return 100 * $urandom_range(YEAR_LIMIT / 100, 1);
      4:       return 4 * $urandom_range(YEAR_LIMIT / 4, 1);
      default: return $urandom_range(YEAR_LIMIT, 1);
    endcase
  endfunction

  // A valid date in year y, often on a month edge so steps roll over.
  function automatic cmd_beat_t valid_date(kind_t k, int unsigned y);
    int unsigned m;
    int unsigned top;
    int unsigned d;
    m   = $urandom_range(12, 1);
    top = last_day(m, y);
    case ($urandom_range(4))
      0:       d = top;
      1:       d = 1;
      2:       d = top - $urandom_range(1);
      default: d = $urandom_range(top, 1);
    endcase
    return mk(k, m, d, y);
  endfunction

  // Any bit pattern in any field, valid or not.
  function automatic cmd_beat_t noise_cmd();
    return mk(kind_t'($urandom_range(3)), $urandom_range(15), $urandom_range(31),
              $urandom_range(16383));
  endfunction

  // A step command; its payload fields are don't-care, so fill them randomly.
  function automatic cmd_beat_t step_cmd(logic forward);
    cmd_beat_t c;
    c      = noise_cmd();
    c.kind = forward ? KIND_NEXT : KIND_PREV;
    return c;
  endfunction

  // Well-formed walk: set a date, step around it, then maybe measure back
  // to an earlier date.
  task automatic queue_walk();
    cmd_beat_t   start;
    int unsigned steps;
    int unsigned mode;
    int unsigned oy;
    start = valid_date(KIND_SET, pick_year());
    queue_cmd(start);
    steps = $urandom_range(8, 1);
    mode  = $urandom_range(2);      // forward, backward or mixed
    repeat (steps) begin
      case (mode)
        0:       queue_cmd(step_cmd(1'b1));
        1:       queue_cmd(step_cmd(1'b0));
        default: queue_cmd(step_cmd($urandom_range(1)));
      endcase
    end
    if ($urandom_range(2) != 0) begin
      if ($urandom_range(3) == 0) begin
        oy = pick_year();
      end else begin
        oy = start.year;
        oy = (oy > 40) ? oy - $urandom_range(40) : $urandom_range(oy, 1);
      end
      queue_cmd(valid_date(KIND_DIFF, oy));
    end
  endtask

  task automatic queue_random(int n);
    int target;
    target = queued + n;
    while (queued < target) begin
      if ($urandom_range(3) == 0) queue_cmd(noise_cmd());
      else queue_walk();
    end
  endtask

  // Let everything queued go out and every result come back.
  task automatic drain();
    while (cmd_q.size() != 0 || cmd.valid || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(int unsigned src, int unsigned snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // Directed corners: range ends, leap rules, every error code, equal and
  // later other dates, the largest possible day count.
  task automatic queue_directed();
    queue_cmd(mk(KIND_SET,  12, 31, YEAR_LIMIT));
    queue_cmd(mk(KIND_NEXT, 0, 0, 0));              // step past the top: held
    queue_cmd(mk(KIND_PREV, 15, 31, 16383));
    queue_cmd(mk(KIND_NEXT, 0, 0, 0));
    queue_cmd(mk(KIND_DIFF, 1, 1, 1));              // largest span
    queue_cmd(mk(KIND_SET,  1, 1, 1));
    queue_cmd(mk(KIND_PREV, 0, 0, 0));              // step below 1/1/1: held
    queue_cmd(mk(KIND_NEXT, 0, 0, 0));
    queue_cmd(mk(KIND_DIFF, 1, 1, 1));              // one day
    queue_cmd(mk(KIND_DIFF, 1, 2, 1));              // same date
    queue_cmd(mk(KIND_DIFF, 5, 5, 2020));           // other date later
    queue_cmd(mk(KIND_SET,  2, 29, 2000));          // 400-year leap
    queue_cmd(mk(KIND_NEXT, 0, 0, 0));
    queue_cmd(mk(KIND_PREV, 0, 0, 0));
    queue_cmd(mk(KIND_DIFF, 2, 30, 2000));          // other date bad day
    queue_cmd(mk(KIND_DIFF, 0, 1, 2000));           // other date bad month
    queue_cmd(mk(KIND_DIFF, 3, 1, 0));              // other date bad year
    queue_cmd(mk(KIND_SET,  2, 29, 1900));          // century non-leap
    queue_cmd(mk(KIND_PREV, 0, 0, 0));
    queue_cmd(mk(KIND_SET,  13, 1, 2000));
    queue_cmd(mk(KIND_SET,  15, 31, 16383));
    queue_cmd(mk(KIND_SET,  6, 15, YEAR_LIMIT + 1));
    queue_cmd(mk(KIND_SET,  4, 31, 2021));
    queue_cmd(mk(KIND_SET,  4, 0, 2021));
    queue_cmd(mk(KIND_SET,  12, 31, 2099));
    queue_cmd(mk(KIND_NEXT, 0, 0, 0));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    @(negedge rst);
    @(negedge clk);

    // no idling at all
    set_idling(0, 0);
    queue_directed();
    queue_random(110);
    drain();

    // sparse commands
    set_idling(72, 0);
    queue_random(110);
    drain();

    // heavy result back-pressure
    set_idling(0, 72);
    queue_random(110);
    drain();

    // both sides idle now and then
    set_idling(21, 21);
    queue_random(110);
    drain();

    // long hold on results while commands keep coming, so the block backs up
    set_idling(0, 0);
    queue_random(110);
    @(negedge clk);
    hold_arm = 1'b1;
    @(negedge clk);
    hold_arm = 1'b0;
    drain();

    // allow any stray beat to show up before the verdict
    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS gregorian_date_counter");
    end else begin
      $display("FAIL gregorian_date_counter");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/gdc_pkg.sv
hdl/gdc_ifs.sv
hdl/gregorian_date_counter.sv
test/tb_top.sv
